// File: design/dvrt_pkg.sv
// ----------------------------------------------------------------------------
// Distance-vector route table package
// Item and result beat types, command and action codes.
// ----------------------------------------------------------------------------
package dvrt_pkg;

  localparam int unsigned NodeW = 6;
  localparam int unsigned DistW = 8;
  localparam int unsigned PortW = 4;
  localparam int unsigned EntryW = DistW + PortW;

  typedef enum logic [1:0] {
    CmdAdvertise = 2'd0,
    CmdFailed    = 2'd1,
    CmdLookup    = 2'd2,
    CmdLinkDown  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ActNone     = 3'd0,
    ActFwdAdv   = 3'd1,
    ActReplyAdv = 3'd2,
    ActFwdFail  = 3'd3,
    ActLookup   = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ReachNone = 2'd0,
    ReachUp   = 2'd1,
    ReachDown = 2'd2
  } reach_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [NodeW-1:0] node_id;
    logic [DistW-1:0] hop_distance;
    logic [PortW-1:0] link_port;
  } item_t;

  typedef struct packed {
    action_e          action;
    logic [NodeW-1:0] out_node;
    logic [DistW-1:0] out_distance;
    logic [PortW-1:0] out_port;
    logic             found;
    reach_e           reach_change;
    logic             last;
  } result_t;

  typedef struct packed {
    logic wr;
    logic set_valid;
    logic clr_valid;
  } ctl_t;

endpackage

// File: design/distance_vector_route_table_top.sv
// ----------------------------------------------------------------------------
// Advertise, failed node and lookup items: the result beat strobes in the
//   cycle busy falls; a new item is taken only once busy is low, so the
//   table read-modify-write of one item ends before the next starts.
// Link down: busy through one table read per node, then drain and the
//   closing beat; up to NODES result beats, the receiver cannot stall.
// Reset: all routes invalid at once, no clearing pass.
// ----------------------------------------------------------------------------
// Distance-vector route table
// Route entries in a RAM with valid flags in flops; a small sequencer drives
// one shared decision unit for item updates and link-down scans.
// ----------------------------------------------------------------------------
module distance_vector_route_table_top
  import dvrt_pkg::*;
#(
  parameter int unsigned NODES = 64
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  item_t   item_i,
  output logic    res_valid_o,
  output result_t result_o
);

  localparam int unsigned IdxW = $clog2(NODES);
  localparam logic [NodeW:0] NodesW = (NodeW+1)'(NODES);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NODES - 1);

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StExec   = 5'b00010,
    StScan   = 5'b00100,
    StDrain  = 5'b01000,
    StFinish = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  item_t             item_q;
  logic [NODES-1:0]  valid_q, valid_d;
  logic [IdxW-1:0]   scan_q, scan_d;
  logic              chk_q, chk_d;
  logic [IdxW-1:0]   chk_idx_q, chk_idx_d;
  logic              pend_q, pend_d;
  logic [IdxW-1:0]   pend_idx_q, pend_idx_d;
  logic              strobe_d;
  result_t           res_d;

  logic              accept;
  logic [IdxW-1:0]   item_idx;
  logic              item_inrange;
  logic [IdxW-1:0]   raddr;
  logic [EntryW-1:0] rdata;
  logic [IdxW-1:0]   alu_idx;
  cmd_e              alu_cmd;
  logic              alu_inrange;
  logic [NodeW-1:0]  alu_node;
  result_t           alu_res;
  ctl_t              alu_ctl;
  logic              ram_we;

  assign accept       = start && !busy;
  assign busy         = (state_q != StIdle);
  assign item_idx     = item_q.node_id[IdxW-1:0];
  assign item_inrange = {1'b0, item_q.node_id} < NodesW;

  assign raddr = (state_q == StScan) ? scan_q : item_i.node_id[IdxW-1:0];

  dvrt_ram #(
    .Width(EntryW),
    .Depth(NODES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(item_idx),
    .wdata_i({alu_res.out_distance, item_q.link_port}),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign alu_idx     = chk_q ? chk_idx_q : item_idx;
  assign alu_cmd     = chk_q ? CmdLinkDown : item_q.cmd;
  assign alu_inrange = chk_q ? 1'b1 : item_inrange;
  assign alu_node    = chk_q ? NodeW'(chk_idx_q) : item_q.node_id;

  dvrt_alu u_alu (
    .cmd_i        (alu_cmd),
    .inrange_i    (alu_inrange),
    .entry_valid_i(alu_inrange && valid_q[alu_idx]),
    .entry_dist_i (rdata[EntryW-1:PortW]),
    .entry_port_i (rdata[PortW-1:0]),
    .node_i       (alu_node),
    .hop_i        (item_q.hop_distance),
    .port_i       (item_q.link_port),
    .res_o        (alu_res),
    .ctl_o        (alu_ctl)
  );

  assign ram_we = (state_q == StExec) && alu_ctl.wr;

  always_comb begin
    state_d    = state_q;
    valid_d    = valid_q;
    scan_d     = scan_q;
    chk_d      = 1'b0;
    chk_idx_d  = chk_idx_q;
    pend_d     = pend_q;
    pend_idx_d = pend_idx_q;
    strobe_d   = 1'b0;
    res_d      = alu_res;

    if (chk_q && alu_ctl.clr_valid) begin
      valid_d[chk_idx_q] = 1'b0;
      pend_d             = 1'b1;
      pend_idx_d         = chk_idx_q;
      if (pend_q) begin
        strobe_d              = 1'b1;
        res_d                 = '0;
        res_d.action          = ActFwdFail;
        res_d.out_node        = NodeW'(pend_idx_q);
        res_d.reach_change    = ReachDown;
        res_d.last            = 1'b0;
      end
    end

    case (state_q)
      StIdle: begin
        if (accept) begin
          scan_d = '0;
          pend_d = 1'b0;
          state_d = (item_i.cmd == CmdLinkDown) ? StScan : StExec;
        end
      end
      StExec: begin
        strobe_d = 1'b1;
        if (alu_ctl.set_valid) begin
          valid_d[item_idx] = 1'b1;
        end
        if (alu_ctl.clr_valid) begin
          valid_d[item_idx] = 1'b0;
        end
        state_d = StIdle;
      end
      StScan: begin
        chk_d     = 1'b1;
        chk_idx_d = scan_q;
        scan_d    = scan_q + IdxW'(1);
        if (scan_q == LastIdx) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StFinish;
      end
      StFinish: begin
        strobe_d = 1'b1;
        res_d    = '0;
        res_d.action       = pend_q ? ActFwdFail : ActNone;
        res_d.out_node     = pend_q ? NodeW'(pend_idx_q) : '0;
        res_d.reach_change = pend_q ? ReachDown : ReachNone;
        res_d.last         = 1'b1;
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      valid_q     <= '0;
      scan_q      <= '0;
      chk_q       <= 1'b0;
      pend_q      <= 1'b0;
      res_valid_o <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      scan_q      <= scan_d;
      chk_q       <= chk_d;
      pend_q      <= pend_d;
      res_valid_o <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
    chk_idx_q  <= chk_idx_d;
    pend_idx_q <= pend_idx_d;
    result_o   <= res_d;
  end

  a_exec_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StExec |=> res_valid_o && result_o.last)
    else $error("item update did not produce a closing beat");

  a_finish_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StFinish |=> res_valid_o && result_o.last)
    else $error("link-down scan did not produce a closing beat");

  a_last_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && result_o.last |-> $past(state_q == StExec || state_q == StFinish))
    else $error("closing beat outside an item end");

  a_chk_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_q |-> (state_q == StScan || state_q == StDrain))
    else $error("scan check active outside a scan");

endmodule

// File: design/dvrt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dvrt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: design/dvrt_alu.sv
// ----------------------------------------------------------------------------
// Route decision unit
// Compares one table entry against a command and forms the result beat and
// the table update.
// ----------------------------------------------------------------------------
module dvrt_alu
  import dvrt_pkg::*;
(
  input  cmd_e             cmd_i,
  input  logic             inrange_i,
  input  logic             entry_valid_i,
  input  logic [DistW-1:0] entry_dist_i,
  input  logic [PortW-1:0] entry_port_i,
  input  logic [NodeW-1:0] node_i,
  input  logic [DistW-1:0] hop_i,
  input  logic [PortW-1:0] port_i,
  output result_t          res_o,
  output ctl_t             ctl_o
);

  logic [DistW-1:0] new_dist;
  logic             port_hit;
  logic             worse;

  assign new_dist = (hop_i == '1) ? hop_i : hop_i + DistW'(1);
  assign port_hit = entry_valid_i && (entry_port_i == port_i);
  assign worse    = ({1'b0, entry_dist_i} + (DistW+1)'(1)) < {1'b0, hop_i};

  always_comb begin
    res_o              = '0;
    res_o.action       = ActNone;
    res_o.reach_change = ReachNone;
    res_o.out_node     = node_i;
    res_o.last         = 1'b1;
    ctl_o              = '0;
    case (cmd_i)
      CmdAdvertise: begin
        if (inrange_i) begin
          if (!entry_valid_i) begin
            ctl_o.wr           = 1'b1;
            ctl_o.set_valid    = 1'b1;
            res_o.action       = ActFwdAdv;
            res_o.out_distance = new_dist;
            res_o.reach_change = ReachUp;
          end else if (entry_dist_i > new_dist) begin
            ctl_o.wr           = 1'b1;
            res_o.action       = ActFwdAdv;
            res_o.out_distance = new_dist;
          end else if (worse) begin
            res_o.action       = ActReplyAdv;
            res_o.out_distance = entry_dist_i;
          end
        end
      end
      CmdFailed: begin
        if (inrange_i) begin
          if (port_hit) begin
            ctl_o.clr_valid    = 1'b1;
            res_o.action       = ActFwdFail;
            res_o.reach_change = ReachDown;
          end else if (entry_valid_i) begin
            res_o.action       = ActReplyAdv;
            res_o.out_distance = entry_dist_i;
          end
        end
      end
      CmdLookup: begin
        res_o.action = ActLookup;
        if (inrange_i && entry_valid_i) begin
          res_o.found        = 1'b1;
          res_o.out_distance = entry_dist_i;
          res_o.out_port     = entry_port_i;
        end
      end
      CmdLinkDown: begin
        if (port_hit) begin
          ctl_o.clr_valid    = 1'b1;
          res_o.action       = ActFwdFail;
          res_o.reach_change = ReachDown;
        end
      end
      default: begin
        res_o.action = ActNone;
      end
    endcase
  end

endmodule
